FILE: rtl/event_ring_fifo_with_stats_defines.svh
// assertion macros for the event ring fifo
// no dependencies; assumes clk and rst_n in the including module
`ifndef EVENT_RING_FIFO_WITH_STATS_DEFINES_SVH
`define EVENT_RING_FIFO_WITH_STATS_DEFINES_SVH

`ifndef SYNTHESIS
`define ERF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ERF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ERF_ASSERT(lbl, prop, msg)
`define ERF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/erf_pkg.sv
// shared types and constants for the event ring fifo
// no dependencies
`default_nettype none

package erf_pkg;

    localparam int CFG_W   = 9;
    localparam int EVENT_W = 64;
    localparam int CNT_W   = 32;
    localparam int LEVEL_W = 8;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [EVENT_W-1:0] event_data;
    } in_item_t;

    typedef struct packed {
        logic               ok;
        logic [EVENT_W-1:0] event_out;
        logic [LEVEL_W-1:0] occupancy;
        logic               empty_res;
        logic [LEVEL_W-1:0] high_water_mark;
        logic [CNT_W-1:0]   drop_count;
        logic [CNT_W-1:0]   push_count;
        logic [CNT_W-1:0]   pop_count;
    } result_t;

    typedef struct packed {
        logic               ok;
        logic [LEVEL_W-1:0] occupancy;
        logic               empty_res;
        logic [LEVEL_W-1:0] high_water_mark;
        logic [CNT_W-1:0]   drop_count;
        logic [CNT_W-1:0]   push_count;
        logic [CNT_W-1:0]   pop_count;
    } stat_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/erf_mem.sv
// slot storage for the event ring fifo, one write and one registered read port
// depends on nothing
`default_nettype none

module erf_mem #(
    parameter int MEM_DEPTH = 256,
    parameter int IW        = 8,
    parameter int WIDTH     = 64
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [IW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [IW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] slot_mem [MEM_DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/erf_ctrl.sv
// ring indices, fill level, peak mark and statistics counters
// depends on erf_pkg and event_ring_fifo_with_stats_defines.svh
`default_nettype none
`include "event_ring_fifo_with_stats_defines.svh"

module erf_ctrl #(
    parameter int MEM_DEPTH = 256,
    parameter int IW        = 8
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [erf_pkg::CFG_W-1:0] cfg_size,
    input  wire logic                     op_valid,
    input  wire logic                     opcode,
    output erf_pkg::mem_ctl_t             mem_ctl,
    output logic      [IW-1:0]            wr_addr,
    output logic      [IW-1:0]            rd_addr,
    output erf_pkg::stat_t                stat
);

    localparam int SW         = $clog2(MEM_DEPTH + 1);
    localparam int RESET_SIZE = (MEM_DEPTH < 256) ? MEM_DEPTH : 256;

    logic [SW-1:0]             size_reg;
    logic [IW-1:0]             wr_idx_reg;
    logic [IW-1:0]             rd_idx_reg;
    logic [IW-1:0]             fill_reg;
    logic [IW-1:0]             peak_reg;
    logic [erf_pkg::CNT_W-1:0] drop_reg;
    logic [erf_pkg::CNT_W-1:0] push_reg;
    logic [erf_pkg::CNT_W-1:0] pop_reg;

    logic [SW-1:0]             size_next;
    logic [IW-1:0]             wr_idx_next;
    logic [IW-1:0]             rd_idx_next;
    logic [IW-1:0]             fill_next;
    logic [IW-1:0]             peak_next;
    logic [erf_pkg::CNT_W-1:0] drop_next;
    logic [erf_pkg::CNT_W-1:0] push_next;
    logic [erf_pkg::CNT_W-1:0] pop_next;

    logic          is_push;
    logic          is_pop;
    logic          full;
    logic          push_ok;
    logic          pop_ok;
    logic [SW-1:0] wr_inc;
    logic [SW-1:0] rd_inc;

    // clamp the written ring size into the usable range
    always_comb
    begin
        priority if (cfg_size < erf_pkg::CFG_W'(2))
        begin
            size_next = SW'(2);
        end
        else if (32'(cfg_size) > 32'(MEM_DEPTH))
        begin
            size_next = SW'(MEM_DEPTH);
        end
        else
        begin
            size_next = SW'(cfg_size);
        end
    end

    always_comb
    begin
        is_push = op_valid && (opcode == erf_pkg::OP_PUSH);
        is_pop  = op_valid && (opcode == erf_pkg::OP_POP);
        full    = (SW'(fill_reg) + SW'(1)) == size_reg;
        push_ok = is_push && !full;
        pop_ok  = is_pop && (fill_reg != '0);

        wr_inc = SW'(wr_idx_reg) + SW'(1);
        rd_inc = SW'(rd_idx_reg) + SW'(1);

        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        fill_next   = fill_reg;
        if (push_ok)
        begin
            wr_idx_next = (wr_inc == size_reg) ? '0 : IW'(wr_inc);
            fill_next   = fill_reg + IW'(1);
        end
        if (pop_ok)
        begin
            rd_idx_next = (rd_inc == size_reg) ? '0 : IW'(rd_inc);
            fill_next   = fill_reg - IW'(1);
        end

        peak_next = (push_ok && (fill_next > peak_reg)) ? fill_next : peak_reg;
        drop_next = (is_push && full) ? drop_reg + 32'd1 : drop_reg;
        push_next = push_ok ? push_reg + 32'd1 : push_reg;
        pop_next  = pop_ok ? pop_reg + 32'd1 : pop_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg   <= SW'(RESET_SIZE);
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            fill_reg   <= '0;
            peak_reg   <= '0;
            drop_reg   <= '0;
            push_reg   <= '0;
            pop_reg    <= '0;
        end
        else if (cfg_we)
        begin
            size_reg   <= size_next;
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            fill_reg   <= '0;
            peak_reg   <= '0;
            drop_reg   <= '0;
            push_reg   <= '0;
            pop_reg    <= '0;
        end
        else if (op_valid)
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            fill_reg   <= fill_next;
            peak_reg   <= peak_next;
            drop_reg   <= drop_next;
            push_reg   <= push_next;
            pop_reg    <= pop_next;
        end
    end

    assign mem_ctl.wr_en = push_ok;
    assign mem_ctl.rd_en = pop_ok;
    assign wr_addr       = wr_idx_reg;
    assign rd_addr       = rd_idx_reg;

    assign stat.ok              = push_ok || pop_ok;
    assign stat.occupancy       = erf_pkg::LEVEL_W'(fill_next);
    assign stat.empty_res       = (wr_idx_next == rd_idx_next);
    assign stat.high_water_mark = erf_pkg::LEVEL_W'(peak_next);
    assign stat.drop_count      = drop_next;
    assign stat.push_count      = push_next;
    assign stat.pop_count       = pop_next;

    `ERF_ASSERT(a_fill_below_size, SW'(fill_reg) < size_reg, "fill level reached ring size")
    `ERF_ASSERT(a_empty_consistent, (wr_idx_reg == rd_idx_reg) == (fill_reg == '0), "index mismatch")
    `ERF_ASSERT_NEXT(a_push_grows, push_ok && !cfg_we, fill_reg == $past(fill_reg) + IW'(1), "push lost")
    `ERF_ASSERT_NEXT(a_pop_advances, pop_ok && !cfg_we, rd_idx_reg != $past(rd_idx_reg), "pop stuck")

endmodule

`default_nettype wire

FILE: rtl/event_ring_fifo_with_stats.sv
// top level of the event ring fifo with statistics
// depends on erf_pkg, erf_ctrl and erf_mem
//
// use:
//   command channel: an item (push or pop) is taken at a clock edge with start
//   high and busy low. busy is high only while a ring size write is offered.
//   result channel: done is high for one cycle with the result; the receiver
//   cannot hold it off, so nothing ever backs up into the command side.
//   config channel: cfg_data is the ring size, written when cfg_valid and
//   cfg_ready are high; cfg_ready is always high. A write empties the ring and
//   clears both indices, the peak mark and the three counters.
// timing:
//   an item goes through an input register, then one pass of index and counter
//   logic with the slot memory access, then the result register, where done
//   and the result are registered together. One item per cycle, back to back,
//   while busy is low.
//   The pop data comes from the memory's registered read port.
// reset:
//   ring size 256 slots (or DEPTH if smaller), ring empty, counters and peak
//   mark zero; slot contents are undefined until written.
`default_nettype none

module event_ring_fifo_with_stats #(
    parameter int DEPTH       = 256,
    parameter int EVENT_WIDTH = 64
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire erf_pkg::in_item_t         cmd,
    output logic                           done,
    output erf_pkg::result_t               result,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [erf_pkg::CFG_W-1:0] cfg_data
);

    localparam int MAX_SIZE  = (1 << erf_pkg::CFG_W) - 1;
    localparam int MEM_DEPTH = (DEPTH < MAX_SIZE) ? DEPTH : MAX_SIZE;
    localparam int IW        = $clog2(MEM_DEPTH);

    logic                   in_valid_reg;
    logic                   in_op_reg;
    logic [EVENT_WIDTH-1:0] in_data_reg;
    logic                   done_reg;
    logic                   pop_ok_reg;
    erf_pkg::stat_t         stat_reg;

    erf_pkg::mem_ctl_t      mem_ctl;
    erf_pkg::stat_t         stat;
    logic [IW-1:0]          wr_addr;
    logic [IW-1:0]          rd_addr;
    logic [EVENT_WIDTH-1:0] rd_data;
    logic                   cfg_we;
    logic                   accept;

    assign busy      = cfg_valid;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            pop_ok_reg   <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
            done_reg     <= in_valid_reg;
            pop_ok_reg   <= in_valid_reg && stat.ok && (in_op_reg == erf_pkg::OP_POP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_op_reg   <= cmd.opcode;
            in_data_reg <= EVENT_WIDTH'(cmd.event_data);
        end
        if (in_valid_reg)
        begin
            stat_reg <= stat;
        end
    end

    erf_ctrl #(
        .MEM_DEPTH (MEM_DEPTH),
        .IW        (IW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_size (cfg_data),
        .op_valid (in_valid_reg),
        .opcode   (in_op_reg),
        .mem_ctl  (mem_ctl),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr),
        .stat     (stat)
    );

    erf_mem #(
        .MEM_DEPTH (MEM_DEPTH),
        .IW        (IW),
        .WIDTH     (EVENT_WIDTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_ctl.wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_data_reg),
        .rd_en   (mem_ctl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign done                   = done_reg;
    assign result.ok              = stat_reg.ok;
    assign result.event_out       = pop_ok_reg ? erf_pkg::EVENT_W'(rd_data) : '0;
    assign result.occupancy       = stat_reg.occupancy;
    assign result.empty_res       = stat_reg.empty_res;
    assign result.high_water_mark = stat_reg.high_water_mark;
    assign result.drop_count      = stat_reg.drop_count;
    assign result.push_count      = stat_reg.push_count;
    assign result.pop_count       = stat_reg.pop_count;

endmodule

`default_nettype wire
